### hdl/assert_macros.svh
// Assertion macros shared by the encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

### hdl/slip_fe_pkg.sv
// Types and constants shared by the SLIP frame encoder modules.
`default_nettype none
package slip_fe_pkg;

  localparam logic [7:0] SLIP_END      = 8'hC0;
  localparam logic [7:0] SLIP_ESC      = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END  = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC  = 8'hDD;
  localparam logic [7:0] SLIP_ESC_XON  = 8'hDE;
  localparam logic [7:0] SLIP_ESC_XOFF = 8'hDF;
  localparam logic [7:0] XON_BYTE      = 8'h11;
  localparam logic [7:0] XOFF_BYTE     = 8'h13;

  // One classified input byte, as handed from front to back.
  typedef struct packed {
    logic       open;   // emit an opening delimiter first
    logic       esc;    // emit an escape byte before the data byte
    logic       close;  // emit a closing delimiter after the data byte
    logic [7:0] data;   // raw byte, or its substitute when escaped
  } cmd_t;

  // Queue fill status seen by front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Which beat of a command the back end emits next.
  typedef enum logic [2:0] {
    PH_START,
    PH_OPEN,
    PH_ESC,
    PH_DATA,
    PH_CLOSE
  } phase_t;

endpackage
`default_nettype wire

### hdl/slip_fe_front.sv
// Front end: accepts raw bytes, tracks the open frame and classifies each byte.
`default_nettype none
module slip_fe_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_data,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,
  input  wire logic               in_tlast,
  input  wire slip_fe_pkg::q_stat_t q_stat,
  output logic                    push,
  output slip_fe_pkg::cmd_t       push_cmd
);
  import slip_fe_pkg::*;

  logic       esc_fc_r, esc_fc_nxt;
  logic       frame_open_r, frame_open_nxt;
  logic       need_esc;
  logic [7:0] sub_byte;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && in_tready;

  // Substitute byte for the escaped codes; flow-control codes only when enabled.
  always_comb begin
    need_esc = 1'b1;
    sub_byte = in_tdata;
    if (in_tdata == SLIP_END) begin
      sub_byte = SLIP_ESC_END;
    end else if (in_tdata == SLIP_ESC) begin
      sub_byte = SLIP_ESC_ESC;
    end else if (esc_fc_r && in_tdata == XON_BYTE) begin
      sub_byte = SLIP_ESC_XON;
    end else if (esc_fc_r && in_tdata == XOFF_BYTE) begin
      sub_byte = SLIP_ESC_XOFF;
    end else begin
      need_esc = 1'b0;
    end
  end

  always_comb begin
    push_cmd.open  = !frame_open_r;
    push_cmd.esc   = need_esc;
    push_cmd.close = in_tlast;
    push_cmd.data  = sub_byte;
  end

  always_comb begin
    esc_fc_nxt     = (cfg_valid && cfg_ready) ? cfg_data : esc_fc_r;
    frame_open_nxt = push ? !in_tlast : frame_open_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_fc_r     <= 1'b0;
      frame_open_r <= 1'b0;
    end else begin
      esc_fc_r     <= esc_fc_nxt;
      frame_open_r <= frame_open_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/slip_fe_queue.sv
// Two-entry command queue between the front and back ends.
`default_nettype none
`include "assert_macros.svh"
module slip_fe_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire slip_fe_pkg::cmd_t  push_cmd,
  input  wire logic               pop,
  output slip_fe_pkg::cmd_t       head_cmd,
  output slip_fe_pkg::q_stat_t    q_stat
);
  import slip_fe_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign head_cmd     = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `ASSERT_NEVER(a_no_overfill, clk, rst_n, push && q_stat.full, "push into full queue")
  `ASSERT_NEVER(a_no_underrun, clk, rst_n, pop && q_stat.empty, "pop from empty queue")
  `ASSERT_NEVER(a_count_range, clk, rst_n, count_r == 2'd3, "queue count out of range")

endmodule
`default_nettype wire

### hdl/slip_fe_back.sv
// Back end: expands each queued command into output beats through an output register.
`default_nettype none
`include "assert_macros.svh"
module slip_fe_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire slip_fe_pkg::cmd_t    head_cmd,
  input  wire slip_fe_pkg::q_stat_t q_stat,
  output logic                      pop,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [7:0]                out_tdata,
  output logic                      out_tlast,
  output logic                      out_tuser
);
  import slip_fe_pkg::*;

  phase_t     phase_r, phase_nxt;
  phase_t     cur_ph;
  logic       load;
  logic [7:0] beat_byte;
  logic       beat_last;
  logic       beat_done;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_done_r;

  assign load = !q_stat.empty && (!out_valid_r || out_tready);
  assign pop  = load && beat_last;

  // At the start of a command the first beat depends on what it carries.
  assign cur_ph = (phase_r != PH_START) ? phase_r :
                  head_cmd.open         ? PH_OPEN :
                  head_cmd.esc          ? PH_ESC  : PH_DATA;

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    if (load) begin
      unique case (cur_ph)
        PH_OPEN:  phase_nxt = head_cmd.esc ? PH_ESC : PH_DATA;
        PH_ESC:   phase_nxt = PH_DATA;
        PH_DATA:  phase_nxt = head_cmd.close ? PH_CLOSE : PH_START;
        PH_CLOSE: phase_nxt = PH_START;
        default:  phase_nxt = PH_START;
      endcase
    end
  end

  // Beat contents for the current phase.
  always_comb begin
    beat_byte = head_cmd.data;
    beat_last = 1'b0;
    beat_done = 1'b0;
    unique case (cur_ph)
      PH_OPEN:  beat_byte = SLIP_END;
      PH_ESC:   beat_byte = SLIP_ESC;
      PH_DATA: begin
        beat_byte = head_cmd.data;
        beat_last = !head_cmd.close;
      end
      PH_CLOSE: begin
        beat_byte = SLIP_END;
        beat_last = 1'b1;
        beat_done = 1'b1;
      end
      default:  beat_byte = head_cmd.data;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= beat_byte;
      out_last_r <= beat_last;
      out_done_r <= beat_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

  `ASSERT_PROP(a_close, clk, rst_n, out_valid_r && out_done_r |-> out_byte_r == SLIP_END, "bad close")
  `ASSERT_PROP(a_close_last, clk, rst_n, out_valid_r && out_done_r |-> out_last_r, "close not last")
  `ASSERT_PROP(a_esc, clk, rst_n, load && cur_ph == PH_ESC |=> phase_r == PH_DATA, "lost escape")
  `ASSERT_PROP(a_mid_cmd_holds, clk, rst_n, phase_r != PH_START |-> !q_stat.empty, "early pop")

endmodule
`default_nettype wire

### hdl/slip_frame_encoder.sv
// Top level of the SLIP frame encoder: front end, command queue and back end.
`default_nettype none
// SLIP frame encoder. Raw packet bytes arrive on the in_ stream, one byte per beat, with
// in_tlast marking the final byte of each packet (a packet always holds at least one byte).
// The out_ stream carries the framed byte stream: an opening 0xC0 before the first byte of
// a packet, 0xC0 sent as DB DC and 0xDB as DB DD, and a closing 0xC0 after the last byte.
// When the configuration bit is set, 0x11 is also sent as DB DE and 0x13 as DB DF. Each
// input byte gives one to four output beats; out_tlast marks the last beat caused by an
// input byte, and out_tuser marks the closing delimiter. The front end takes an input beat
// in any cycle in which the two-entry command queue has room, so bytes may arrive back to
// back while earlier ones are still being sent. The back end sends one output beat per
// cycle while out_tready is high, through a registered output stage, so an input byte holds the
// output for as many beats as it gives (one for a plain byte in mid-frame, up to four for an
// escaped single-byte packet); sustained throughput is set by that output stage. Output
// data passes through a queue entry and then the output register. The configuration bit
// should be written only while the encoder is idle; it resets to zero, as does the frame
// state.
module slip_frame_encoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Configuration: escape_flow_control.
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data,    // [0] escape_flow_control
  // Raw byte stream.
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,    // [7:0] raw_byte
  input  wire logic       in_tlast,    // packet_end
  // Framed byte stream.
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,   // [7:0] coded_byte
  output logic            out_tlast,   // run_last
  output logic            out_tuser    // [0] frame_done
);
  import slip_fe_pkg::*;

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  cmd_t    push_cmd;
  cmd_t    head_cmd;

  // The front end owns the frame-open state, so commands are fully classified on entry.
  slip_fe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // The queue lets the input side keep accepting while the output side is stalled.
  slip_fe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  // The back end releases a command only once its last beat is loaded for output.
  slip_fe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_cmd   (head_cmd),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

### bench/slip_frame_encoder_tb.sv
// Self-checking testbench for the SLIP frame encoder: directed and random packets, both escape modes.
`timescale 1ns / 1ps

// One beat of the framed output stream, as predicted or as seen on out_.
typedef struct packed {
  logic [7:0] coded_byte;
  logic       run_last;
  logic       frame_done;
} coded_beat_t;

// Keeps its own copy of the frame state and the escape mode, turns every accepted raw byte
// into the beats it should cause, and matches the beats that leave the encoder against them.
class slip_stream_checker;
  bit          flow_escape;
  bit          in_frame;
  int          mismatches;
  coded_beat_t awaited_beats[$];

  function void take_raw_byte(logic [7:0] raw, logic pkt_end);
    coded_beat_t beats[4];
    logic [7:0]  subst;
    int          n;
    n = 0;
    subst = 8'h00;
    if (!in_frame) begin
      beats[n] = '{slip_fe_pkg::SLIP_END, 1'b0, 1'b0};
      n++;
      in_frame = 1'b1;
    end
    if (raw == slip_fe_pkg::SLIP_END) subst = slip_fe_pkg::SLIP_ESC_END;
    else if (raw == slip_fe_pkg::SLIP_ESC) subst = slip_fe_pkg::SLIP_ESC_ESC;
    else if (flow_escape && raw == slip_fe_pkg::XON_BYTE) subst = slip_fe_pkg::SLIP_ESC_XON;
    else if (flow_escape && raw == slip_fe_pkg::XOFF_BYTE) subst = slip_fe_pkg::SLIP_ESC_XOFF;
    if (subst != 8'h00) begin
      beats[n] = '{slip_fe_pkg::SLIP_ESC, 1'b0, 1'b0};
      beats[n + 1] = '{subst, 1'b0, 1'b0};
      n += 2;
    end else begin
      beats[n] = '{raw, 1'b0, 1'b0};
      n++;
    end
    if (pkt_end) begin
      beats[n] = '{slip_fe_pkg::SLIP_END, 1'b0, 1'b1};
      n++;
      in_frame = 1'b0;
    end
    beats[n - 1].run_last = 1'b1;
    for (int i = 0; i < n; i++) awaited_beats.push_back(beats[i]);
  endfunction

  function void check_coded_beat(coded_beat_t got);
    coded_beat_t want;
    if (awaited_beats.size() == 0) begin
      $error("unexpected output beat: coded_byte %02h run_last %0d frame_done %0d",
             got.coded_byte, got.run_last, got.frame_done);
      mismatches++;
      return;
    end
    want = awaited_beats.pop_front();
    if (got.coded_byte !== want.coded_byte) begin
      $error("coded_byte: expected %02h, got %02h", want.coded_byte, got.coded_byte);
      mismatches++;
    end
    if (got.run_last !== want.run_last) begin
      $error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
      mismatches++;
    end
    if (got.frame_done !== want.frame_done) begin
      $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
      mismatches++;
    end
  endfunction
endclass

module slip_frame_encoder_tb;

  // Far beyond the slowest legal run: about 350 bytes, four beats each, the receiver
  // taking one beat in four, plus sender gaps and the idle pauses between phases.
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASES = 4;
  localparam int PHASE_BYTES = 80;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  slip_stream_checker sb;
  int burst_left = 0;
  int cycle_count = 0;
  int rx_cycle = 0;
  int rx_mode = 0;

  // Bytes that the encoder may escape, followed by the four substitute codes.
  logic [7:0] special_bytes[8] = '{slip_fe_pkg::SLIP_END, slip_fe_pkg::SLIP_ESC,
                                   slip_fe_pkg::XON_BYTE, slip_fe_pkg::XOFF_BYTE,
                                   slip_fe_pkg::SLIP_ESC_END, slip_fe_pkg::SLIP_ESC_ESC,
                                   slip_fe_pkg::SLIP_ESC_XON, slip_fe_pkg::SLIP_ESC_XOFF};

  slip_frame_encoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost beat ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The receiver switches at random between four stall patterns: always ready, a coin toss per
  // cycle, ready a quarter of the time, or ready five eighths of the time. The always-ready
  // stretches leave the output free of stalls for a while, the others put stalls between beats.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 256 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      2: out_tready <= (rx_cycle % 4 == 0);
      default: out_tready <= (rx_cycle % 16 < 10);
    endcase
  end

  // An output beat counts at an edge where out_tvalid and out_tready were both high; the
  // values read here are those from before the edge, so nothing races the encoder.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_coded_beat('{out_tdata, out_tlast, out_tuser});
  end

  // Offer one raw byte and wait for its beat to be taken. The sender works in bursts; when
  // one runs out it usually drops in_tvalid for a few cycles before the next begins, but a
  // quarter of the time the next burst follows straight on.
  task automatic send_byte(input logic [7:0] raw, input logic pkt_end);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= raw;
    in_tlast  <= pkt_end;
    do @(posedge clk); while (!in_tready);
    sb.take_raw_byte(raw, pkt_end);
  endtask

  // Stop sending and wait until every predicted beat has left the encoder, then a few
  // more cycles so that anything stray still has the chance to show up.
  task automatic drain_output();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.awaited_beats.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Configuration write; only ever called with the encoder idle.
  task automatic write_escape_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.flow_escape = mode;
  endtask

  initial begin
    int sent;
    int pkt_len;
    logic [7:0] raw;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, escape mode off: a single-byte packet, a packet carrying END, ESC, XON and
    // XOFF (XON and XOFF must pass through untouched here), and single-byte packets that
    // need an escape pair, which give all four beats from one byte.
    write_escape_mode(1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(slip_fe_pkg::SLIP_END, 1'b0);
    send_byte(slip_fe_pkg::SLIP_ESC, 1'b0);
    send_byte(slip_fe_pkg::XON_BYTE, 1'b0);
    send_byte(slip_fe_pkg::XOFF_BYTE, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(slip_fe_pkg::SLIP_END, 1'b1);
    send_byte(slip_fe_pkg::SLIP_ESC, 1'b1);
    drain_output();

    // Escape mode on: XON and XOFF now escape, the substitute codes themselves do not.
    write_escape_mode(1'b1);
    foreach (special_bytes[i]) send_byte(special_bytes[i], 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(slip_fe_pkg::XON_BYTE, 1'b1);
    send_byte(slip_fe_pkg::XOFF_BYTE, 1'b1);

    // Escape mode changed while a frame is open: each byte follows the mode in force when
    // it arrives, and the frame stays open across the pause.
    send_byte(slip_fe_pkg::XON_BYTE, 1'b0);
    send_byte(slip_fe_pkg::XOFF_BYTE, 1'b0);
    drain_output();
    write_escape_mode(1'b0);
    send_byte(slip_fe_pkg::XON_BYTE, 1'b0);
    send_byte(slip_fe_pkg::XOFF_BYTE, 1'b1);
    drain_output();

    // Random part: phases of random packets, the escape mode alternating between phases.
    // A phase may stop in mid-packet, so the mode also changes inside a frame now and then.
    // Now and again the sender also holds back until the output has fully drained.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_escape_mode((ph % 2) == 0);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        pkt_len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 20);
        for (int k = 0; k < pkt_len && sent < PHASE_BYTES; k++) begin
          raw = ($urandom_range(0, 3) == 0) ? special_bytes[$urandom_range(0, 7)]
                                            : 8'($urandom_range(0, 255));
          send_byte(raw, k == pkt_len - 1);
          sent++;
        end
        if ($urandom_range(0, 29) == 0) drain_output();
      end
      drain_output();
    end

    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
